FILE: design/ptrt_pkg.sv
// shared types, constants and helpers for the pixel trim tuning block
`default_nettype none

package ptrt_pkg;

    localparam int PIXELS_DEFAULT = 4160;
    localparam int CNT_W          = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    localparam logic [7:0] TRIG_RESET  = 8'd1;
    localparam logic [7:0] VTRIM_RESET = 8'd60;
    localparam logic [3:0] TRIM_INIT   = 4'd7;
    localparam logic [3:0] TRIM_MAX    = 4'd15;

    localparam logic [7:0] VTRIM_LIMIT = 8'd250;
    localparam logic [8:0] VTRIM_SAT   = 9'd255;
    localparam logic [7:0] STEP_LARGE  = 8'd24;
    localparam logic [7:0] STEP_MID    = 8'd8;
    localparam logic [7:0] STEP_SMALL  = 8'd4;

    localparam logic [CNT_W-1:0] REQ_MIN  = 13'd5;
    localparam logic [CNT_W-1:0] REQ_MID  = 13'd50;
    localparam logic [CNT_W-1:0] REQ_HIGH = 13'd100;

    // configuration register indexes
    localparam logic CFG_TRIGGER_COUNT = 1'b0;
    localparam logic CFG_VTRIM_START   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_PIXEL = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic [7:0] hits_at;
        logic [7:0] hits_above;
        logic [7:0] hits_below;
        logic [7:0] hits_large;
        logic [3:0] trim;
        logic [3:0] best_trim;
        logic [7:0] best_dist;
    } t_step_in;

    typedef struct packed {
        logic [3:0] trim;
        logic [3:0] best_trim;
        logic [7:0] best_dist;
        logic       dist_write;
        logic       changed;
        logic       wants;
    } t_step_out;

    typedef struct packed {
        logic [CNT_W-1:0] action_total;
        logic [CNT_W-1:0] request_total;
        logic             vtrim_raised;
        logic [7:0]       vtrim_value;
        logic             wants_larger_vtrim;
        logic             trim_changed;
        logic [3:0]       trim_value;
    } t_result;

    function automatic logic [11:0] times10(input logic [7:0] v);
        return {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + 1'b1 : CNT_MAX;
    endfunction

endpackage

`default_nettype wire

FILE: design/ptrt_ram.sv
// single-port-write, single-port-read synchronous memory, registered read
`default_nettype none

module ptrt_ram #(
    parameter int DEPTH = ptrt_pkg::PIXELS_DEFAULT,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/ptrt_step.sv
// trim decision for one pixel measurement
`default_nettype none

module ptrt_step (
    input  wire logic [7:0]         i_ntrig,
    input  wire ptrt_pkg::t_step_in i_step,
    output ptrt_pkg::t_step_out     o_step
);

    logic [11:0] w_at10, w_ab10, w_be10, w_lg10, w_diff10;
    logic [11:0] w_n1, w_n2, w_n5, w_n7, w_n9;
    logic [7:0]  w_half, w_dist, w_diff;
    logic        w_all_low;

    assign w_at10 = ptrt_pkg::times10(i_step.hits_at);
    assign w_ab10 = ptrt_pkg::times10(i_step.hits_above);
    assign w_be10 = ptrt_pkg::times10(i_step.hits_below);
    assign w_lg10 = ptrt_pkg::times10(i_step.hits_large);

    assign w_n1 = {4'b0000, i_ntrig};
    assign w_n2 = {3'b000, i_ntrig, 1'b0};
    assign w_n5 = {2'b00, i_ntrig, 2'b00} + {4'b0000, i_ntrig};
    assign w_n7 = {1'b0, i_ntrig, 3'b000} - {4'b0000, i_ntrig};
    assign w_n9 = {1'b0, i_ntrig, 3'b000} + {4'b0000, i_ntrig};

    // below minus above, only meaningful when positive
    assign w_diff   = i_step.hits_below - i_step.hits_above;
    assign w_diff10 = ptrt_pkg::times10(w_diff);

    assign w_half = {1'b0, i_ntrig[7:1]};
    assign w_dist = (i_step.hits_at >= w_half) ? i_step.hits_at - w_half
                                               : w_half - i_step.hits_at;

    assign w_all_low = (w_ab10 < w_n1) && (w_be10 < w_n1) && (w_at10 < w_n1);

    always_comb begin
        logic       v_up;
        logic       v_down;
        logic       v_better;
        logic       v_normal;
        logic [3:0] v_t;

        v_up     = 1'b0;
        v_down   = 1'b0;
        v_better = 1'b0;
        v_normal = 1'b0;
        o_step.wants = 1'b0;

        if (w_all_low) begin
            if (w_lg10 > w_n9) begin
                v_down = 1'b1;
            end else begin
                v_up = 1'b1;
            end
        end else if (w_lg10 < w_n5) begin
            v_up = 1'b1;
        end else if ((i_step.hits_below > i_step.hits_above) && (w_diff10 > w_n1)) begin
            v_up = 1'b1;
        end else if (w_be10 > w_n5) begin
            v_up = 1'b1;
        end else begin
            v_normal = 1'b1;
            v_better = (w_dist < i_step.best_dist);
            if ((i_step.hits_below < i_step.hits_at) &&
                (i_step.hits_at < i_step.hits_above)) begin
                if (w_at10 > w_n7) begin
                    v_up = 1'b1;
                end else if (w_at10 < w_n2) begin
                    v_down = 1'b1;
                end
            end
        end

        // a distance no better than the best falls back to the best trim seen so far
        v_t = (v_normal && !v_better) ? i_step.best_trim : i_step.trim;

        o_step.changed = 1'b0;
        if (v_up && (v_t != ptrt_pkg::TRIM_MAX)) begin
            v_t = v_t + 1'b1;
            o_step.changed = 1'b1;
        end else if (v_down) begin
            if (v_t != 4'd0) begin
                v_t = v_t - 1'b1;
                o_step.changed = 1'b1;
            end else if (v_normal) begin
                // still too high a threshold at trim zero
                o_step.wants = 1'b1;
            end
        end

        o_step.trim       = v_t;
        o_step.best_trim  = v_better ? i_step.trim : i_step.best_trim;
        o_step.best_dist  = w_dist;
        o_step.dist_write = v_better;
    end

endmodule

`default_nettype wire

FILE: design/pixel_trim_retune_step.sv
// top level of the pixel trim tuning block
`default_nettype none

// Trim tuning for the pixels of one readout chip. Per-pixel state (trim and
// best trim in one memory, best distance in a second) lives in synchronous
// memories with a registered read. An item transfer on the s_axis side
// selects by tuser: begin run, pixel measurement, end of pass, or read
// final trim. Every item yields exactly one result transfer on m_axis. For
// pixel and read items the transfer cycle issues the memory read; the
// decision state then forms the result and, for a pixel item, does the trim
// decision and writes back, so a following item reads the updated entry
// without forwarding. After its decision a begin item sweeps both memories
// one entry per cycle; an end of pass item sweeps the best distances the
// same way when it raises vtrim. After reset the block runs the same
// clearing pass before it accepts the first item; configuration writes are
// taken at any time and should be issued only while the block is idle. A
// result may wait in the output register while the next item is accepted;
// the decision cycle of that item then waits until the held result is taken.
module pixel_trim_retune_step #(
    parameter int PIXELS = ptrt_pkg::PIXELS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [12:0] pixel_index, [20:13] hits_at, [28:21] hits_above,
    // [36:29] hits_below, [44:37] hits_large, [47:45] zero
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] trim_value, [4] trim_changed, [5] wants_larger_vtrim,
    // [13:6] vtrim_value, [14] vtrim_raised, [27:15] request_total,
    // [40:28] action_total, [47:41] zero
    output logic      [47:0] m_axis_tdata,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CW = ptrt_pkg::CNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

    // control state
    ptrt_pkg::t_state  r_state, n_state;
    logic              r_sweep_all;
    logic [AW-1:0]     r_sweep_addr;
    logic [7:0]        r_fill;
    logic              r_out_valid;

    // registers and counters
    logic [7:0]        r_trig, r_vstart, r_vtrim;
    logic [CW-1:0]     r_req, r_act;

    // captured item
    ptrt_pkg::t_func   r_func;
    logic [12:0]       r_pix;
    logic [7:0]        r_at, r_ab, r_be, r_lg;
    ptrt_pkg::t_result r_out;

    // memory ports
    logic              w_we_trim, w_we_dist, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [7:0]        w_wdata_trim, w_rdata_trim;
    logic [7:0]        w_wdata_dist, w_rdata_dist;

    logic              w_accept, w_out_free, w_calc_fire, w_sweep_last;
    logic              w_in_range, w_raise;
    logic [16:0]       w_pix_ext, w_in_pix_ext;
    logic [8:0]        w_vtrim_sum;
    logic [7:0]        w_vstep;

    ptrt_pkg::t_step_in  w_step_in;
    ptrt_pkg::t_step_out w_step_out;
    ptrt_pkg::t_result   n_out;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_sweep_last = (r_sweep_addr == LAST_ADDR);

    assign w_pix_ext    = {4'b0000, r_pix};
    assign w_in_pix_ext = {4'b0000, s_axis_tdata[12:0]};
    assign w_in_range   = (w_pix_ext < 17'(PIXELS));

    // end of pass vtrim raise
    assign w_raise = (r_req > ptrt_pkg::REQ_MIN) && (r_vtrim < ptrt_pkg::VTRIM_LIMIT);
    assign w_vstep = (r_req > ptrt_pkg::REQ_HIGH) ? ptrt_pkg::STEP_LARGE :
                     (r_req > ptrt_pkg::REQ_MID)  ? ptrt_pkg::STEP_MID   :
                                                    ptrt_pkg::STEP_SMALL;
    assign w_vtrim_sum = {1'b0, r_vtrim} + {1'b0, w_vstep};

    // memories: trim word is {best_trim, trim}
    ptrt_ram #(.DEPTH(PIXELS), .WIDTH(8)) u_trim_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_trim),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_trim),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_trim)
    );

    ptrt_ram #(.DEPTH(PIXELS), .WIDTH(8)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_dist),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_dist),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_dist)
    );

    assign w_step_in.hits_at    = r_at;
    assign w_step_in.hits_above = r_ab;
    assign w_step_in.hits_below = r_be;
    assign w_step_in.hits_large = r_lg;
    assign w_step_in.trim       = w_rdata_trim[3:0];
    assign w_step_in.best_trim  = w_rdata_trim[7:4];
    assign w_step_in.best_dist  = w_rdata_dist;

    ptrt_step u_step (
        .i_ntrig (r_trig),
        .i_step  (w_step_in),
        .o_step  (w_step_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptrt_pkg::ST_SWEEP: begin
                if (w_sweep_last) begin
                    n_state = ptrt_pkg::ST_IDLE;
                end
            end
            ptrt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = ptrt_pkg::ST_CALC;
                end
            end
            ptrt_pkg::ST_CALC: begin
                if (w_out_free) begin
                    if ((r_func == ptrt_pkg::FUNC_BEGIN) ||
                        ((r_func == ptrt_pkg::FUNC_END) && w_raise)) begin
                        n_state = ptrt_pkg::ST_SWEEP;
                    end else begin
                        n_state = ptrt_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = ptrt_pkg::ST_SWEEP;
        endcase
    end

    // state outputs: handshake and memory ports
    always_comb begin
        s_axis_tready = 1'b0;
        w_re          = 1'b0;
        w_calc_fire   = 1'b0;
        w_we_trim     = 1'b0;
        w_we_dist     = 1'b0;
        w_waddr       = r_sweep_addr;
        w_wdata_trim  = {ptrt_pkg::TRIM_INIT, ptrt_pkg::TRIM_INIT};
        w_wdata_dist  = r_fill;
        w_raddr       = w_in_pix_ext[AW-1:0];
        case (r_state)
            ptrt_pkg::ST_SWEEP: begin
                w_we_trim = r_sweep_all;
                w_we_dist = 1'b1;
            end
            ptrt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_re          = 1'b1;
            end
            ptrt_pkg::ST_CALC: begin
                w_calc_fire  = w_out_free;
                w_waddr      = w_pix_ext[AW-1:0];
                w_wdata_trim = {w_step_out.best_trim, w_step_out.trim};
                w_wdata_dist = w_step_out.best_dist;
                if (w_out_free && (r_func == ptrt_pkg::FUNC_PIXEL) && w_in_range) begin
                    w_we_trim = 1'b1;
                    w_we_dist = w_step_out.dist_write;
                end
            end
            default: begin
                w_we_trim = 1'b0;
            end
        endcase
    end

    // result of the item in the decision cycle
    always_comb begin
        n_out                    = '0;
        n_out.vtrim_value        = r_vtrim;
        n_out.request_total      = r_req;
        n_out.action_total       = r_act;
        case (r_func)
            ptrt_pkg::FUNC_BEGIN: begin
                n_out.vtrim_value   = r_vstart;
                n_out.request_total = '0;
                n_out.action_total  = '0;
            end
            ptrt_pkg::FUNC_PIXEL: begin
                if (w_in_range) begin
                    n_out.trim_value         = w_step_out.trim;
                    n_out.trim_changed       = w_step_out.changed;
                    n_out.wants_larger_vtrim = w_step_out.wants;
                    if (w_step_out.changed) begin
                        n_out.action_total = ptrt_pkg::count_up(r_act);
                    end
                    if (w_step_out.wants) begin
                        n_out.request_total = ptrt_pkg::count_up(r_req);
                    end
                end
            end
            ptrt_pkg::FUNC_END: begin
                if (w_raise) begin
                    n_out.vtrim_raised = 1'b1;
                    n_out.vtrim_value  = (w_vtrim_sum > ptrt_pkg::VTRIM_SAT) ?
                                         8'hFF : w_vtrim_sum[7:0];
                end
            end
            ptrt_pkg::FUNC_READ: begin
                if (w_in_range) begin
                    n_out.trim_value = w_rdata_trim[7:4];
                end
            end
            default: n_out = '0;
        endcase
    end

    // control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptrt_pkg::ST_SWEEP;
            r_sweep_all  <= 1'b1;
            r_sweep_addr <= '0;
            r_fill       <= ptrt_pkg::TRIG_RESET;
            r_out_valid  <= 1'b0;
            r_trig       <= ptrt_pkg::TRIG_RESET;
            r_vstart     <= ptrt_pkg::VTRIM_RESET;
            r_vtrim      <= ptrt_pkg::VTRIM_RESET;
            r_req        <= '0;
            r_act        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ptrt_pkg::CFG_TRIGGER_COUNT: r_trig   <= i_cfg_data;
                    ptrt_pkg::CFG_VTRIM_START:   r_vstart <= i_cfg_data;
                    default:                     r_trig   <= r_trig;
                endcase
            end

            if (r_state == ptrt_pkg::ST_SWEEP) begin
                r_sweep_addr <= w_sweep_last ? '0 : r_sweep_addr + 1'b1;
            end

            // a new result replaces the one taken in the same cycle
            if (w_calc_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_calc_fire) begin
                r_vtrim     <= n_out.vtrim_value;
                r_fill      <= r_trig;
                // begin sweeps both memories, end of pass only distances
                r_sweep_all <= (r_func == ptrt_pkg::FUNC_BEGIN);
                if (r_func == ptrt_pkg::FUNC_END) begin
                    r_req <= '0;
                    r_act <= '0;
                end else begin
                    r_req <= n_out.request_total;
                    r_act <= n_out.action_total;
                end
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= ptrt_pkg::t_func'(s_axis_tuser);
            r_pix  <= s_axis_tdata[12:0];
            r_at   <= s_axis_tdata[20:13];
            r_ab   <= s_axis_tdata[28:21];
            r_be   <= s_axis_tdata[36:29];
            r_lg   <= s_axis_tdata[44:37];
        end
        if (w_calc_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0000000, r_out};

    // an accepted item always moves to the decision cycle
    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ptrt_pkg::ST_CALC))
        else $error("accepted item did not enter decision cycle");

    // a new result only comes out of the decision cycle
    a_result_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(r_state == ptrt_pkg::ST_CALC))
        else $error("result appeared outside decision cycle");

    // pixel write-back only for an in-range pixel item
    a_write_pixel_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we_trim && (r_state == ptrt_pkg::ST_CALC)) |->
            ((r_func == ptrt_pkg::FUNC_PIXEL) && w_in_range))
        else $error("memory write-back for non-pixel item");

    // no item is taken while a sweep runs
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we_dist && (r_state == ptrt_pkg::ST_SWEEP)) |=>
            ($past(w_sweep_last) || !s_axis_tready))
        else $error("item accepted during memory sweep");

endmodule

`default_nettype wire
